### hdl/gelu_tanh_activation_assert.svh
// ----------------------------------------------------------------------------
// GELU activation assertion macros
// Shared concurrent assertion forms for the GELU datapath.
// ----------------------------------------------------------------------------
`ifndef GELU_TANH_ACTIVATION_ASSERT_SVH
`define GELU_TANH_ACTIVATION_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GTA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define GTA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/gta_pkg.sv
// ----------------------------------------------------------------------------
// GELU activation package
// Fixed-point formats, constants and shared types of the GELU datapath.
// ----------------------------------------------------------------------------
package gta_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 11;

    // Internal magnitude formats: Q24 for the polynomial, Q30 for tanh.
    localparam int Q24_FRAC = 24;
    localparam int Q30_FRAC = 30;
    localparam int A24_W    = 28;
    localparam int SQ_W     = 31;
    localparam int CUBE_W   = 34;
    localparam int INNER_W  = 30;
    localparam int U24_W    = 30;
    localparam int H_W      = 30;
    localparam int R_W      = 31;

    localparam logic [R_W-1:0] Q30_ONE = R_W'(1) << Q30_FRAC;

    // 0.044715 and sqrt(2/pi) in Q32.
    localparam logic [27:0] C1_Q32 = 28'd192049463;
    localparam logic [31:0] K_Q32  = 32'd3426888095;

    // exp(-u/8) series length and the squarings that raise it to exp(-2u).
    localparam int EXP_TERMS     = 14;
    localparam int EXP_SQUARINGS = 4;

    // Pipelined divider for (1-E)/(1+E).
    localparam int DEN_W              = 32;
    localparam int DIV_Q_W            = 32;
    localparam int DIV_BITS_PER_STAGE = 2;

    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

endpackage

### hdl/gelu_tanh_activation.sv
// ----------------------------------------------------------------------------
// GELU activation, tanh form
// y = 0.5*z*(1 + tanh(sqrt(2/pi)*(z + 0.044715*z^3))) on signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   One sample z (signed, FRAC_BITS fractional bits) enters per beat on the
//   s_axis channel, and GELU(z) leaves in the same format on m_axis, in order.
//   Samples are independent, so a new one is taken every cycle while
//   s_axis_tready is high. The path runs through five polynomial stages,
//   28 stages of the exp(-u/8) series (multiply, then constant divide, per
//   term), four squarings, a 17-stage tanh divider (a set-up stage, then
//   two quotient bits per stage), two output-scaling stages and the output
//   register. Reset clears every valid bit; no other register is reset.
//   When m_axis_tready is low, the output register holds its beat and a skid
//   register catches the next result; only once that skid register is full
//   does s_axis_tready fall and the whole pipeline freeze, with nothing lost
//   or repeated. Ready is driven straight from a register.
// ----------------------------------------------------------------------------
`include "gelu_tanh_activation_assert.svh"

module gelu_tanh_activation #(
    parameter int DATA_WIDTH = gta_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = gta_pkg::FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [(((DATA_WIDTH + 7) >> 3) << 3) - 1:0] s_axis_tdata,  // z_in
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [(((DATA_WIDTH + 7) >> 3) << 3) - 1:0] m_axis_tdata   // y_out
);
    import gta_pkg::*;

    localparam int TdW   = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int SdW   = DATA_WIDTH + 1;
    localparam int SideW = DATA_WIDTH + 2;
    localparam int CW    = (DATA_WIDTH > FRAC_BITS + 4) ? DATA_WIDTH : FRAC_BITS + 4;
    localparam int CW1   = CW + 1;
    localparam int SqPW  = 2 * A24_W;
    localparam int CuPW  = SQ_W + A24_W;
    localparam int CtPW  = 62;
    localparam int FW    = DEN_W;
    localparam int PW    = DATA_WIDTH + FW;
    localparam logic [CW-1:0] Lim = CW'(8) << FRAC_BITS;

    logic pipe_en;
    logic out_pop;

    // Stage 1: magnitude, clamp to 8.0 and conversion to Q24.
    logic [DATA_WIDTH-1:0] raw;
    logic                  neg;
    logic [DATA_WIDTH-1:0] mag;
    logic [CW-1:0]         mag_ext;
    logic [CW-1:0]         ac;
    logic [A24_W-1:0]      a24;

    always_comb begin
        raw     = s_axis_tdata[DATA_WIDTH-1:0];
        neg     = raw[DATA_WIDTH-1];
        mag     = neg ? (~raw + 1'b1) : raw;
        mag_ext = CW'(mag);
        ac      = (mag_ext < Lim) ? mag_ext : Lim;
    end

    if (FRAC_BITS <= Q24_FRAC) begin : g_up
        localparam int Up = Q24_FRAC - FRAC_BITS;
        logic [CW+Q24_FRAC-1:0] ac_wide;

        assign ac_wide = {{Q24_FRAC{1'b0}}, ac} << Up;
        assign a24     = ac_wide[A24_W-1:0];
    end else begin : g_dn
        localparam int Dn = FRAC_BITS - Q24_FRAC;
        logic [CW:0] ac_rnd;

        assign ac_rnd = ({1'b0, ac} + (CW1'(1) << (Dn - 1))) >> Dn;
        assign a24    = ac_rnd[A24_W-1:0];
    end

    logic             r_v1;
    logic [SdW-1:0]   r_sd1;
    logic [A24_W-1:0] r_a24_1;

    // Stage 2: square.
    logic [SqPW-1:0]  sq_prod;
    logic             r_v2;
    logic [SdW-1:0]   r_sd2;
    logic [A24_W-1:0] r_a24_2;
    logic [SQ_W-1:0]  r_sq2;

    assign sq_prod = SqPW'(r_a24_1) * SqPW'(r_a24_1) + (SqPW'(1) << (Q24_FRAC - 1));

    // Stage 3: cube.
    logic [CuPW-1:0]   cu_prod;
    logic              r_v3;
    logic [SdW-1:0]    r_sd3;
    logic [A24_W-1:0]  r_a24_3;
    logic [CUBE_W-1:0] r_cube3;

    assign cu_prod = CuPW'(r_sq2) * CuPW'(r_a24_2) + (CuPW'(1) << (Q24_FRAC - 1));

    // Stage 4: a + 0.044715*a^3.
    logic [CtPW-1:0]    ct_prod;
    logic [INNER_W-1:0] inner;
    logic               r_v4;
    logic [SdW-1:0]     r_sd4;
    logic [INNER_W-1:0] r_inner4;

    always_comb begin
        ct_prod = CtPW'(r_cube3) * CtPW'(C1_Q32) + (CtPW'(1) << 31);
        inner   = ct_prod[CtPW-1:32] + INNER_W'(r_a24_3);
    end

    // Stage 5: u = sqrt(2/pi)*inner, range check and h = u/8 in Q30.
    logic [CtPW-1:0]  u_prod;
    logic [U24_W-1:0] u24;
    logic             r_v5;
    logic [SideW-1:0] r_side5;
    logic [H_W-1:0]   r_h5;

    always_comb begin
        u_prod = CtPW'(r_inner4) * CtPW'(K_Q32) + (CtPW'(1) << 31);
        u24    = u_prod[CtPW-1:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (pipe_en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_sd1    <= {neg, mag};
            r_a24_1  <= a24;
            r_sd2    <= r_sd1;
            r_a24_2  <= r_a24_1;
            r_sq2    <= sq_prod[SQ_W+Q24_FRAC-1:Q24_FRAC];
            r_sd3    <= r_sd2;
            r_a24_3  <= r_a24_2;
            r_cube3  <= cu_prod[CUBE_W+Q24_FRAC-1:Q24_FRAC];
            r_sd4    <= r_sd3;
            r_inner4 <= inner;
            // At u >= 8.0 tanh is taken as exactly one.
            r_side5  <= {(|u24[U24_W-1:27]), r_sd4};
            r_h5     <= {u24[26:0], 3'b000};
        end
    end

    // exp(-2u) and tanh.
    logic             exp_vld;
    logic [R_W-1:0]   exp_e;
    logic [SideW-1:0] exp_side;
    logic             div_vld;
    logic [R_W-1:0]   div_q;
    logic [SideW-1:0] div_side;

    gta_exp_pipe #(
        .SIDE_W (SideW)
    ) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: pipe_en, vld: r_v5}),
        .i_h     (r_h5),
        .i_side  (r_side5),
        .o_vld   (exp_vld),
        .o_e     (exp_e),
        .o_side  (exp_side)
    );

    gta_div_pipe #(
        .SIDE_W (SideW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: pipe_en, vld: exp_vld}),
        .i_e     (exp_e),
        .i_side  (exp_side),
        .o_vld   (div_vld),
        .o_q     (div_q),
        .o_side  (div_side)
    );

    // Stage 6: factor 1 + T for positive inputs, 1 - T for negative ones.
    logic [R_W-1:0]   tanh_q;
    logic [FW-1:0]    fac;
    logic             r_v6;
    logic [SideW-1:0] r_sd6;
    logic [FW-1:0]    r_f6;

    always_comb begin
        tanh_q = div_side[SideW-1] ? Q30_ONE : div_q;
        fac    = div_side[DATA_WIDTH] ? (FW'(Q30_ONE) - FW'(tanh_q))
                                      : (FW'(Q30_ONE) + FW'(tanh_q));
    end

    // Stage 7: |y| = |z|*factor/2^31 rounded half up, then the sign.
    logic [PW-1:0]         y_prod;
    logic [DATA_WIDTH-1:0] y_mag;
    logic [DATA_WIDTH-1:0] y_val;
    logic                  r_v7;
    logic [DATA_WIDTH-1:0] r_y7;

    always_comb begin
        y_prod = PW'(r_sd6[DATA_WIDTH-1:0]) * PW'(r_f6) + (PW'(1) << Q30_FRAC);
        y_mag  = y_prod[DATA_WIDTH+Q30_FRAC:Q30_FRAC+1];
        y_val  = r_sd6[DATA_WIDTH] ? (~y_mag + 1'b1) : y_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (pipe_en) begin
            r_v6 <= div_vld;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_sd6 <= div_side;
            r_f6  <= fac;
            r_y7  <= y_val;
        end
    end

    // Output register with a skid register behind it.
    logic                  r_out_vld;
    logic [DATA_WIDTH-1:0] r_out_y;
    logic                  r_skid_vld;
    logic [DATA_WIDTH-1:0] r_skid_y;
    logic                  n_out_vld;
    logic [DATA_WIDTH-1:0] n_out_y;
    logic                  n_skid_vld;
    logic [DATA_WIDTH-1:0] n_skid_y;

    assign pipe_en = !r_skid_vld;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_out_y    = r_out_y;
        n_skid_vld = r_skid_vld;
        n_skid_y   = r_skid_y;
        out_pop    = r_out_vld && m_axis_tready;
        if (r_skid_vld) begin
            if (out_pop) begin
                n_out_y    = r_skid_y;
                n_skid_vld = 1'b0;
            end
        end else if (r_v7) begin
            if (!r_out_vld || out_pop) begin
                n_out_vld = 1'b1;
                n_out_y   = r_y7;
            end else begin
                n_skid_vld = 1'b1;
                n_skid_y   = r_y7;
            end
        end else if (out_pop) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_y  <= n_out_y;
        r_skid_y <= n_skid_y;
    end

    assign s_axis_tready = pipe_en;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = TdW'(r_out_y);

    `GTA_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld, "skid full while output register empty")
    `GTA_ASSERT_NXT(a_freeze_holds, i_clk, i_rst_n, !pipe_en, $stable(r_v7) && $stable(r_y7), "pipeline moved while frozen")
    `GTA_ASSERT_IMP(a_tanh_range, i_clk, i_rst_n, div_vld, div_q <= Q30_ONE, "tanh quotient above one")
    `GTA_ASSERT_IMP(a_neg_sat_zero, i_clk, i_rst_n, r_v6 && r_sd6[DATA_WIDTH] && r_sd6[SideW-1], r_f6 == '0, "large negative input gives nonzero factor")

endmodule

### hdl/gta_exp_pipe.sv
// ----------------------------------------------------------------------------
// GELU exponential pipeline
// Computes exp(-2u) in Q30 from h = u/8: a Horner series of exp(-h) with one
// multiply stage and one constant-divide stage per term, then four squarings.
// ----------------------------------------------------------------------------
module gta_exp_pipe #(
    parameter int SIDE_W = gta_pkg::DATA_WIDTH_DEF + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gta_pkg::t_pipe_ctl    i_ctl,
    input  logic [gta_pkg::H_W-1:0] i_h,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_vld,
    output logic [gta_pkg::R_W-1:0] o_e,
    output logic [SIDE_W-1:0]     o_side
);
    import gta_pkg::*;

    localparam int HornStages = 2 * EXP_TERMS;
    localparam int Stages     = HornStages + EXP_SQUARINGS;
    localparam int PW         = H_W + R_W;
    localparam int SqW        = 2 * R_W;

    logic              r_vld  [Stages];
    logic [SIDE_W-1:0] r_side [Stages];
    logic [R_W-1:0]    r_val  [Stages];
    logic [H_W-1:0]    r_h    [HornStages];

    for (genvar s = 0; s < Stages; s++) begin : g_stage
        logic              vld_in;
        logic [SIDE_W-1:0] side_in;
        logic [R_W-1:0]    val_in;
        logic [R_W-1:0]    n_val;

        if (s == 0) begin : g_first
            assign vld_in  = i_ctl.vld;
            assign side_in = i_side;
            assign val_in  = Q30_ONE;
        end else begin : g_next
            assign vld_in  = r_vld[s-1];
            assign side_in = r_side[s-1];
            assign val_in  = r_val[s-1];
        end

        if (s < HornStages) begin : g_horner
            logic [H_W-1:0] h_in;

            if (s == 0) begin : g_h_first
                assign h_in = i_h;
            end else begin : g_h_next
                assign h_in = r_h[s-1];
            end

            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_h[s] <= h_in;
                end
            end

            if ((s % 2) == 0) begin : g_mul
                logic [PW-1:0] prod;

                always_comb begin
                    prod  = PW'(h_in) * PW'(val_in);
                    n_val = {1'b0, prod[2*Q30_FRAC-1:Q30_FRAC]};
                end
            end else begin : g_div
                // Exact reciprocal: the product is below 2^30, so a multiply by
                // ceil(2^Shift / Divisor) and a shift gives the floor quotient.
                localparam int Divisor = EXP_TERMS - s / 2;
                localparam int Shift   = Q30_FRAC + $clog2(Divisor);
                localparam logic [63:0] Magic =
                    ((64'd1 << Shift) + 64'(Divisor) - 64'd1) / 64'(Divisor);

                logic [PW-1:0] prod;
                logic [PW-1:0] quo_wide;

                always_comb begin
                    prod     = PW'(val_in[H_W-1:0]) * PW'(Magic[R_W-1:0]);
                    quo_wide = prod >> Shift;
                    n_val    = Q30_ONE - quo_wide[R_W-1:0];
                end
            end
        end else begin : g_sqr
            logic [SqW-1:0] prod;

            always_comb begin
                prod  = SqW'(val_in) * SqW'(val_in) + (SqW'(1) << (Q30_FRAC - 1));
                n_val = prod[R_W+Q30_FRAC-1:Q30_FRAC];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_side[s] <= side_in;
                r_val[s]  <= n_val;
            end
        end
    end

    assign o_vld  = r_vld[Stages-1];
    assign o_e    = r_val[Stages-1];
    assign o_side = r_side[Stages-1];

endmodule

### hdl/gta_div_pipe.sv
// ----------------------------------------------------------------------------
// GELU tanh divider
// Forms tanh = (1-E)/(1+E) in Q30 with round half up, as a restoring
// divider that retires two quotient bits in each stage after the set-up stage.
// ----------------------------------------------------------------------------
module gta_div_pipe #(
    parameter int SIDE_W = gta_pkg::DATA_WIDTH_DEF + 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  gta_pkg::t_pipe_ctl      i_ctl,
    input  logic [gta_pkg::R_W-1:0] i_e,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_vld,
    output logic [gta_pkg::R_W-1:0] o_q,
    output logic [SIDE_W-1:0]       o_side
);
    import gta_pkg::*;

    localparam int Stages = 1 + DIV_Q_W / DIV_BITS_PER_STAGE;
    localparam int RemW   = DEN_W + 1;
    localparam int NfW    = R_W + Q30_FRAC;

    logic               r_vld  [Stages];
    logic [SIDE_W-1:0]  r_side [Stages];
    logic [RemW-1:0]    r_rem  [Stages];
    logic [DIV_Q_W-1:0] r_num  [Stages];
    logic [DIV_Q_W-1:0] r_quo  [Stages];
    logic [DEN_W-1:0]   r_den  [Stages];

    for (genvar s = 0; s < Stages; s++) begin : g_stage
        logic               vld_in;
        logic [SIDE_W-1:0]  side_in;
        logic [RemW-1:0]    n_rem;
        logic [DIV_Q_W-1:0] n_num;
        logic [DIV_Q_W-1:0] n_quo;
        logic [DEN_W-1:0]   n_den;

        if (s == 0) begin : g_prep
            logic [R_W-1:0] num_hi;
            logic [NfW-1:0] num_full;

            // Numerator (1-E)*2^30 plus half the divisor, for round half up.
            always_comb begin
                vld_in   = i_ctl.vld;
                side_in  = i_side;
                n_den    = DEN_W'(i_e) + DEN_W'(Q30_ONE);
                num_hi   = Q30_ONE - i_e;
                num_full = {num_hi, {Q30_FRAC{1'b0}}} + NfW'(n_den[DEN_W-1:1]);
                n_rem    = RemW'(num_full[NfW-1:DIV_Q_W]);
                n_num    = num_full[DIV_Q_W-1:0];
                n_quo    = '0;
            end
        end else begin : g_step
            always_comb begin
                vld_in  = r_vld[s-1];
                side_in = r_side[s-1];
                n_den   = r_den[s-1];
                n_rem   = r_rem[s-1];
                n_num   = r_num[s-1];
                n_quo   = r_quo[s-1];
                for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
                    n_rem = {n_rem[DEN_W-1:0], n_num[DIV_Q_W-1]};
                    n_num = {n_num[DIV_Q_W-2:0], 1'b0};
                    if (n_rem >= {1'b0, n_den}) begin
                        n_rem = n_rem - {1'b0, n_den};
                        n_quo = {n_quo[DIV_Q_W-2:0], 1'b1};
                    end else begin
                        n_quo = {n_quo[DIV_Q_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_side[s] <= side_in;
                r_rem[s]  <= n_rem;
                r_num[s]  <= n_num;
                r_quo[s]  <= n_quo;
                r_den[s]  <= n_den;
            end
        end
    end

    // The rounded quotient never exceeds 2^30, so it always fits in the low R_W bits.
    assign o_vld  = r_vld[Stages-1];
    assign o_q    = r_quo[Stages-1][R_W-1:0];
    assign o_side = r_side[Stages-1];

endmodule
